// ----- rtl/upsc_pkg.sv -----
// upsc_pkg: shared types, constants and the url character class for the
// url prefix scanner. No dependencies; imported by every rtl file of the block.
package upsc_pkg;

    // position counter saturates here
    localparam int MAX_LEN = 512;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int START_W = 9;
    localparam int LEN_W   = 10;

    // characters of the prefix, and the NUL terminator
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // punctuation allowed inside a url
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    // prefix matcher states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_H,
        ST_T1,
        ST_T2,
        ST_P,
        ST_S,
        ST_COL,
        ST_DONE
    } state_t;

    // one step's result toward the output register
    typedef struct packed {
        logic               emit;
        logic               found;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } result_t;

    // letters of either case, digits and the listed punctuation
    function automatic logic is_url_char(input logic [7:0] c);
        logic ok;
        begin
            case (c) inside
                [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                CH_DOT, CH_SLASH, CH_BSL, CH_TILDE, CH_HASH, CH_PCT, CH_AMP,
                CH_LPAR, CH_RPAR, CH_UNDER, CH_MINUS, CH_PLUS, CH_EQ,
                CH_SEMI, CH_QUEST:
                    ok = 1'b1;
                default:
                    ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

// ----- rtl/url_prefix_scanner_top.sv -----
// url_prefix_scanner_top: input register, matcher and output register of the
// url prefix scanner. Depends on upsc_pkg and upsc_fsm.
//
// Takes one message byte per request with a last flag and finds the first
// "http:" or "https:" url in the message, reporting its start offset and
// length once (found=0 at the last byte if there is none). One byte is taken
// every cycle while in_stall is low; a byte's result enters the output register
// as its byte moves on, through one input and one result register around the
// combinational matcher step. Input stall rises only while a result sits in
// the output register under stall and the next byte is already registered.
module url_prefix_scanner_top
    import upsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_in,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output logic [START_W-1:0] start_res,
    output logic [LEN_W-1:0]   length
);

    logic               in_vld_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    logic               out_vld_reg;
    logic               found_reg;
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               advance;
    result_t            res;

    // the registered byte moves on when the output register can take a result
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= byte_in;
            last_reg <= last;
        end
    end

    // matcher step
    upsc_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .byte_in (byte_reg),
        .last    (last_reg),
        .res     (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= res.emit;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            found_reg <= res.found;
            start_reg <= res.start;
            len_reg   <= res.len;
        end
    end

    assign out_valid = out_vld_reg;
    assign found     = found_reg;
    assign start_res = start_reg;
    assign length    = len_reg;

    // a no-url report carries zero offset and length
    a_nofind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !found_reg |-> start_reg == '0 && len_reg == '0)
        else $error("no-url report with nonzero fields");

    // a url never reaches past the saturated position
    a_url_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && found_reg |->
            ({1'b0, start_reg} + len_reg) <= (LEN_W + 1)'(MAX_LEN))
        else $error("url extends beyond MAX_LEN");

    // a registered byte held by a stalled output stays registered
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && out_stall |=> in_vld_reg)
        else $error("registered byte dropped under output stall");

    // a stalled result is not overwritten by the matcher
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall |-> !advance)
        else $error("matcher stepped into a stalled result");

endmodule

// ----- rtl/upsc_fsm.sv -----
// upsc_fsm: prefix matcher state machine with position, url start and
// reported-flag registers; produces at most one result per byte.
// Depends on upsc_pkg.
module upsc_fsm
    import upsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [7:0]    byte_in,
    input  logic          last,
    output result_t       res
);

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_inc;
    logic [START_W-1:0] start_reg, start_next;
    logic               reported_reg, reported_next;
    logic               term_emit;
    logic [LEN_W-1:0]   len_now, len_inc;

    // saturating position of the following byte
    assign pos_inc = (pos_reg < POS_W'(MAX_LEN)) ? pos_reg + POS_W'(1) : pos_reg;

    // url length at the current and at the following position; start never
    // exceeds position, and position is at most MAX_LEN
    assign len_now = LEN_W'(pos_reg - {1'b0, start_reg});
    assign len_inc = LEN_W'(pos_inc - {1'b0, start_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        if (state_reg != ST_DONE)
        begin
            if (byte_in == CH_NUL)
            begin
                state_next = ST_DONE;
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        if (byte_in == CH_H)
                        begin
                            state_next = ST_H;
                            start_next = (pos_reg >= POS_W'(MAX_LEN))
                                ? START_W'(MAX_LEN - 1) : pos_reg[START_W-1:0];
                        end
                    end
                    ST_H:    state_next = (byte_in == CH_T) ? ST_T1 : ST_IDLE;
                    ST_T1:   state_next = (byte_in == CH_T) ? ST_T2 : ST_IDLE;
                    ST_T2:   state_next = (byte_in == CH_P) ? ST_P : ST_IDLE;
                    ST_P:
                    begin
                        if (byte_in == CH_COLON)
                            state_next = ST_COL;
                        else if (byte_in == CH_S)
                            state_next = ST_S;
                        else
                            state_next = ST_IDLE;
                    end
                    ST_S:    state_next = (byte_in == CH_COLON) ? ST_COL : ST_IDLE;
                    ST_COL:
                    begin
                        if (!is_url_char(byte_in))
                            state_next = ST_DONE;
                    end
                    ST_DONE: state_next = ST_DONE;
                endcase
            end
        end
    end

    // outputs: url end inside the message, or the end-of-message report
    always_comb
    begin
        term_emit = (state_reg == ST_COL) &&
                    ((byte_in == CH_NUL) || !is_url_char(byte_in));
        res       = '0;
        if (term_emit)
        begin
            res.emit  = 1'b1;
            res.found = 1'b1;
            res.start = start_reg;
            res.len   = len_now;
        end
        else if (last && !reported_reg)
        begin
            res.emit = 1'b1;
            if (state_next == ST_COL)
            begin
                res.found = 1'b1;
                res.start = start_reg;
                res.len   = len_inc;
            end
        end
    end

    // register updates; the end of a message restores the reset values
    always_comb
    begin
        pos_next      = pos_inc;
        reported_next = reported_reg | term_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            start_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else if (step_en)
        begin
            if (last)
            begin
                state_reg    <= ST_IDLE;
                pos_reg      <= '0;
                start_reg    <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                state_reg    <= state_next;
                pos_reg      <= pos_next;
                start_reg    <= start_next;
                reported_reg <= reported_next;
            end
        end
    end

endmodule
